### hw/rtl/per_source_sequence_replay_filter_top_assert.svh
// ---------------------------------------------------------------------------
// replay filter assertion macros
// shorthand for the concurrent checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef PER_SOURCE_SEQUENCE_REPLAY_FILTER_TOP_ASSERT_SVH
`define PER_SOURCE_SEQUENCE_REPLAY_FILTER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define RPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rpf_pkg.sv
// ---------------------------------------------------------------------------
// replay filter package
// field widths, stream widths and the shared compare unit interface types
// ---------------------------------------------------------------------------
package rpf_pkg;

	localparam int unsigned ID_W      = 64;
	localparam int unsigned SEQ_W     = 32;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned S_TDATA_W = ID_W + SEQ_W + TIME_W;
	localparam int unsigned M_TDATA_W = 8;

	// operands for the shared compare unit
	typedef struct packed {
		logic [ID_W-1:0]   a;
		logic [ID_W-1:0]   b;
		logic [TIME_W-1:0] c;
		logic [TIME_W-1:0] d;
	} cmp_req_t;

	// compare flags: a equals b, c below d, a is zero
	typedef struct packed {
		logic eq;
		logic lt;
		logic a_zero;
	} cmp_res_t;

endpackage

### hw/rtl/rpf_cmp.sv
// ---------------------------------------------------------------------------
// replay filter compare unit
// one equality, one unsigned less-than and one zero test, shared by both scans
// ---------------------------------------------------------------------------
module rpf_cmp (
	input  rpf_pkg::cmp_req_t req,
	output rpf_pkg::cmp_res_t res
);
	import rpf_pkg::*;

	assign res.eq     = (req.a == req.b);
	assign res.lt     = (req.c < req.d);
	assign res.a_zero = (req.a == '0);

endmodule

### hw/rtl/per_source_sequence_replay_filter_top.sv
// ---------------------------------------------------------------------------
// per-source sequence replay filter
// Each input item carries a source id, a sequence number and a timestamp in
// ms, and yields one output item: already_seen is 1 when that sequence number
// is among the last WINDOW_DEPTH numbers recorded for that source, else 0 and
// the number is recorded. Source id 0 always gives 0 and changes nothing. A
// table of SOURCE_SLOTS slots tracks sources; a source not in the table takes
// the first empty slot, or else the slot touched longest ago (lowest index on
// ties), which starts over with an empty window. One item is handled at a
// time: a scan reads every slot of the table once through the single read
// port of the slot memory, then the chosen slot's window is read entry by
// entry, only the entries held for that source (up to WINDOW_DEPTH), one
// word per cycle, both scans feeding one shared compare unit. An item with
// source id 0 skips both scans. The next item is taken only once the result
// has been loaded into the output register. After reset the slot table is
// cleared in a pass over all SOURCE_SLOTS slots before the first item is
// taken. A finished result waits in the output register while the next item
// is taken in; the next result is held back until it drains.
// ---------------------------------------------------------------------------
`include "per_source_sequence_replay_filter_top_assert.svh"

module per_source_sequence_replay_filter_top #(
	parameter int unsigned SOURCE_SLOTS = 256,
	parameter int unsigned WINDOW_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [63:0] source_id, [95:64] sequence_number, [159:96] timestamp_ms
	input  logic [rpf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// output items
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] already_seen, [7:1] zero
	output logic [rpf_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
	import rpf_pkg::*;

	// derived widths
	localparam int unsigned SI_W       = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
	localparam int unsigned CNT_W      = $clog2(SOURCE_SLOTS + 1);
	localparam int unsigned HEAD_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned FILL_W     = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned RING_DEPTH = SOURCE_SLOTS * WINDOW_DEPTH;
	localparam int unsigned RA_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	// one row of the slot table
	typedef struct packed {
		logic [ID_W-1:0]   source;
		logic [TIME_W-1:0] touch;
		logic [HEAD_W-1:0] head;
		logic [FILL_W-1:0] fill;
	} slot_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SEL,
		ST_BASE,
		ST_RSCAN,
		ST_DONE
	} state_t;

	// memories
	slot_t              slot_mem [SOURCE_SLOTS];
	logic [SEQ_W-1:0]   ring_mem [RING_DEPTH];

	state_t             state_q;

	// item held while it is worked on
	logic [ID_W-1:0]    src_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [TIME_W-1:0]  now_q;
	logic               skip_q;   // source id 0: no table update

	// slot scan
	logic [SI_W-1:0]    clr_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               rd_valid_s1;
	logic [SI_W-1:0]    rd_idx_s1;
	slot_t              slot_rdata_s1;
	logic               match_found_q;
	logic [SI_W-1:0]    match_idx_q;
	logic [HEAD_W-1:0]  match_head_q;
	logic [FILL_W-1:0]  match_fill_q;
	logic               empty_found_q;
	logic [SI_W-1:0]    empty_idx_q;
	logic [TIME_W-1:0]  oldest_time_q;
	logic [SI_W-1:0]    oldest_idx_q;

	// window scan
	logic [SI_W-1:0]    sel_q;
	logic [HEAD_W-1:0]  head_q;
	logic [FILL_W-1:0]  fill_q;
	logic [RA_W-1:0]    ring_base_q;
	logic [FILL_W-1:0]  ring_idx_q;
	logic               ring_valid_s1;
	logic [SEQ_W-1:0]   ring_rdata_s1;
	logic               hit_q;

	// combinational control
	logic               in_accept;
	logic               out_load;
	logic               slot_re;
	logic [SI_W-1:0]    slot_raddr;
	logic               slot_we;
	logic [SI_W-1:0]    slot_waddr;
	slot_t              slot_wdata;
	logic               ring_re;
	logic [RA_W-1:0]    ring_raddr;
	logic               ring_we;
	logic [RA_W-1:0]    ring_waddr;
	logic [HEAD_W-1:0]  head_next;
	logic [FILL_W-1:0]  fill_next;
	cmp_req_t           cmp_req;
	cmp_res_t           cmp_res;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	// result goes out once the output register is free
	assign out_load      = (state_q == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

	// slot table read port: one row per cycle during the scan
	assign slot_re    = (state_q == ST_SCAN) && (scan_idx_q != CNT_W'(SOURCE_SLOTS));
	assign slot_raddr = scan_idx_q[SI_W-1:0];

	// window read port: entries below the fill count only
	assign ring_re    = (state_q == ST_RSCAN) && (ring_idx_q != fill_q);
	assign ring_raddr = ring_base_q + RA_W'(ring_idx_q);

	// ring head wraps, fill saturates at the window size
	assign head_next = (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign fill_next = (fill_q == FILL_W'(WINDOW_DEPTH)) ? fill_q : fill_q + 1'b1;

	// slot table write port: clearing pass, then one update per item with a nonzero source id
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = sel_q;
		slot_wdata = '0;
		if (state_q == ST_CLEAR) begin
			slot_we    = 1'b1;
			slot_waddr = clr_q;
		end else if (out_load && !skip_q) begin
			slot_we           = 1'b1;
			slot_wdata.source = src_q;
			slot_wdata.touch  = now_q;
			slot_wdata.head   = hit_q ? head_q : head_next;
			slot_wdata.fill   = hit_q ? fill_q : fill_next;
		end
	end

	// a miss records the number at the ring head
	assign ring_we    = out_load && !skip_q && !hit_q;
	assign ring_waddr = ring_base_q + RA_W'(head_q);

	// shared compare unit: slot rows during the slot scan, window words after
	always_comb begin
		cmp_req.c = slot_rdata_s1.touch;
		cmp_req.d = oldest_time_q;
		if (state_q == ST_RSCAN) begin
			cmp_req.a = ID_W'(ring_rdata_s1);
			cmp_req.b = ID_W'(seq_q);
		end else begin
			cmp_req.a = slot_rdata_s1.source;
			cmp_req.b = src_q;
		end
	end

	rpf_cmp u_cmp (
		.req (cmp_req),
		.res (cmp_res)
	);

	// slot table memory
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rdata_s1 <= slot_mem[slot_raddr];
		end
	end

	// window memory, never cleared: a claimed slot starts with fill 0
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= seq_q;
		end
		if (ring_re) begin
			ring_rdata_s1 <= ring_mem[ring_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			src_q         <= '0;
			seq_q         <= '0;
			now_q         <= '0;
			skip_q        <= 1'b0;
			scan_idx_q    <= '0;
			rd_valid_s1   <= 1'b0;
			rd_idx_s1     <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			match_head_q  <= '0;
			match_fill_q  <= '0;
			empty_found_q <= 1'b0;
			empty_idx_q   <= '0;
			oldest_time_q <= '1;
			oldest_idx_q  <= '0;
			sel_q         <= '0;
			head_q        <= '0;
			fill_q        <= '0;
			ring_base_q   <= '0;
			ring_idx_q    <= '0;
			ring_valid_s1 <= 1'b0;
			hit_q         <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			// output register drains independently of the sequencer
			if (m_axis_tvalid && m_axis_tready && !out_load) begin
				m_axis_tvalid <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SI_W'(SOURCE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (in_accept) begin
						src_q         <= s_axis_tdata[ID_W-1:0];
						seq_q         <= s_axis_tdata[ID_W+SEQ_W-1:ID_W];
						now_q         <= s_axis_tdata[S_TDATA_W-1:ID_W+SEQ_W];
						skip_q        <= (s_axis_tdata[ID_W-1:0] == '0);
						hit_q         <= 1'b0;
						scan_idx_q    <= '0;
						rd_valid_s1   <= 1'b0;
						match_found_q <= 1'b0;
						empty_found_q <= 1'b0;
						oldest_time_q <= '1;
						oldest_idx_q  <= '0;
						if (s_axis_tdata[ID_W-1:0] == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end

				ST_SCAN: begin
					// issue side
					if (slot_re) begin
						rd_valid_s1 <= 1'b1;
						rd_idx_s1   <= slot_raddr;
						scan_idx_q  <= scan_idx_q + 1'b1;
					end else begin
						rd_valid_s1 <= 1'b0;
						if (!rd_valid_s1) begin
							state_q <= ST_SEL;
						end
					end
					// evaluate side, one row behind
					if (rd_valid_s1) begin
						if (cmp_res.eq && !match_found_q) begin
							match_found_q <= 1'b1;
							match_idx_q   <= rd_idx_s1;
							match_head_q  <= slot_rdata_s1.head;
							match_fill_q  <= slot_rdata_s1.fill;
						end
						if (cmp_res.a_zero && !empty_found_q) begin
							empty_found_q <= 1'b1;
							empty_idx_q   <= rd_idx_s1;
						end
						// strict less-than keeps the lowest index on ties
						if (cmp_res.lt) begin
							oldest_time_q <= slot_rdata_s1.touch;
							oldest_idx_q  <= rd_idx_s1;
						end
					end
				end

				ST_SEL: begin
					// matching slot, else first empty, else least recently touched
					if (match_found_q) begin
						sel_q  <= match_idx_q;
						head_q <= match_head_q;
						fill_q <= match_fill_q;
					end else begin
						sel_q  <= empty_found_q ? empty_idx_q : oldest_idx_q;
						head_q <= '0;
						fill_q <= '0;
					end
					ring_idx_q    <= '0;
					ring_valid_s1 <= 1'b0;
					state_q       <= ST_BASE;
				end

				ST_BASE: begin
					ring_base_q <= RA_W'(sel_q) * RA_W'(WINDOW_DEPTH);
					state_q     <= ST_RSCAN;
				end

				ST_RSCAN: begin
					if (ring_re) begin
						ring_valid_s1 <= 1'b1;
						ring_idx_q    <= ring_idx_q + 1'b1;
					end else begin
						ring_valid_s1 <= 1'b0;
						if (!ring_valid_s1) begin
							state_q <= ST_DONE;
						end
					end
					if (ring_valid_s1 && cmp_res.eq) begin
						hit_q <= 1'b1;
					end
				end

				ST_DONE: begin
					if (out_load) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= M_TDATA_W'(hit_q);
						state_q       <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks

	// the window scan never reads past the entries held for the slot
	`RPF_ASSERT_IMP(a_ring_idx_bound, state_q == ST_RSCAN, ring_idx_q <= fill_q, "window scan past fill count")

	// a stored fill count never exceeds the window size
	`RPF_ASSERT_IMP(a_fill_bound, slot_we, slot_wdata.fill <= FILL_W'(WINDOW_DEPTH), "fill count above window size")

	// a source is held in at most one slot
	`RPF_ASSERT_IMP(a_unique_match, (state_q == ST_SCAN) && rd_valid_s1 && cmp_res.eq, !match_found_q, "source found in two slots")

	// a finished item shows up on the output in the next cycle
	`RPF_ASSERT_NXT(a_result_shown, out_load, m_axis_tvalid, "result not presented after load")

endmodule
